>>> rtl/etb_pkg.sv
package etb_pkg;

    localparam int ELEV_W  = 20;
    localparam int TEXEL_W = 24;
    localparam int CH_W    = 8;
    localparam int N_CH    = 3;
    localparam int N_TEX   = 6;

    localparam int DEF_ELEV_FRAC_BITS   = 4;
    localparam int DEF_WEIGHT_FRAC_BITS = 16;

    localparam int LANE_LAT  = 4;
    localparam int MERGE_LAT = 3;
    localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

    localparam int LVL_1    = 1;
    localparam int LVL_5    = 5;
    localparam int LVL_10   = 10;
    localparam int LVL_20   = 20;
    localparam int LVL_25   = 25;
    localparam int LVL_100  = 100;
    localparam int LVL_500  = 500;
    localparam int LVL_600  = 600;
    localparam int LVL_800  = 800;
    localparam int LVL_1000 = 1000;
    localparam int LVL_1500 = 1500;
    localparam int LVL_5000 = 5000;

    typedef enum logic [1:0] {
        SH_FALL,
        SH_TRI,
        SH_TRAP,
        SH_RISE
    } t_shape;

    typedef enum logic [1:0] {
        W_ZERO,
        W_ONE,
        W_RAMP
    } t_wcls;

endpackage

>>> rtl/elevation_texture_blend.sv
// Channel   Dir  Handshake              Words
// command   in   start & !busy          i_elevation, i_texel_* (six)
// result    out  o_valid, one cycle     o_out_red, o_out_green, o_out_blue
//
// One word is taken every clock; busy stays low.
// Words pass through the weight lanes (compare, reciprocal multiply,
// back-multiply, remainder correction), then the merge (products, adder tree, clamp).
// Reset clears only the strobe pipeline; data registers run free.
// The receiver cannot stall: each result shows for exactly one cycle.
module elevation_texture_blend import etb_pkg::*; #(
    parameter int ELEV_FRAC_BITS   = DEF_ELEV_FRAC_BITS,
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [ELEV_W-1:0] i_elevation,
    input  logic [TEXEL_W-1:0]       i_texel_water,
    input  logic [TEXEL_W-1:0]       i_texel_mud,
    input  logic [TEXEL_W-1:0]       i_texel_grass_a,
    input  logic [TEXEL_W-1:0]       i_texel_grass_b,
    input  logic [TEXEL_W-1:0]       i_texel_stone_a,
    input  logic [TEXEL_W-1:0]       i_texel_stone_b,
    output logic                     o_valid,
    output logic [CH_W-1:0]          o_out_red,
    output logic [CH_W-1:0]          o_out_green,
    output logic [CH_W-1:0]          o_out_blue
);

    localparam int WF = WEIGHT_FRAC_BITS;
    localparam longint ONE_M = longint'(1) << ELEV_FRAC_BITS;
    localparam logic signed [ELEV_W:0] ELEV_ONE_M = (ELEV_W + 1)'(ONE_M);

    logic [WF:0]          weight [N_TEX];
    logic [TEXEL_W-1:0]   tex_in [N_TEX];
    logic [TEXEL_W-1:0]   r_tex  [LANE_LAT][N_TEX];
    logic [CH_W-1:0]      chan   [N_CH];
    logic [TOTAL_LAT-1:0] r_vld;
    logic [TOTAL_LAT-1:0] n_vld;

    assign busy = 1'b0;

    assign tex_in[0] = i_texel_water;
    assign tex_in[1] = i_texel_mud;
    assign tex_in[2] = i_texel_grass_a;
    assign tex_in[3] = i_texel_grass_b;
    assign tex_in[4] = i_texel_stone_a;
    assign tex_in[5] = i_texel_stone_b;

    etb_lane #(
        .ELEV_FRAC_BITS(ELEV_FRAC_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
        .P_SHAPE(SH_FALL), .P_A(LVL_1), .P_B(LVL_10)
    ) u_lane_water (
        .i_clk(i_clk), .i_elevation(i_elevation), .o_weight(weight[0])
    );

    etb_lane #(
        .ELEV_FRAC_BITS(ELEV_FRAC_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
        .P_SHAPE(SH_TRI), .P_A(LVL_1), .P_B(LVL_5), .P_C(LVL_20)
    ) u_lane_mud (
        .i_clk(i_clk), .i_elevation(i_elevation), .o_weight(weight[1])
    );

    etb_lane #(
        .ELEV_FRAC_BITS(ELEV_FRAC_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
        .P_SHAPE(SH_TRAP), .P_A(LVL_5), .P_B(LVL_25), .P_C(LVL_500), .P_D(LVL_600)
    ) u_lane_grass_a (
        .i_clk(i_clk), .i_elevation(i_elevation), .o_weight(weight[2])
    );

    etb_lane #(
        .ELEV_FRAC_BITS(ELEV_FRAC_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
        .P_SHAPE(SH_TRAP), .P_A(LVL_10), .P_B(LVL_100), .P_C(LVL_800), .P_D(LVL_1000)
    ) u_lane_grass_b (
        .i_clk(i_clk), .i_elevation(i_elevation), .o_weight(weight[3])
    );

    etb_lane #(
        .ELEV_FRAC_BITS(ELEV_FRAC_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
        .P_SHAPE(SH_RISE), .P_A(LVL_500), .P_B(LVL_1500)
    ) u_lane_stone_a (
        .i_clk(i_clk), .i_elevation(i_elevation), .o_weight(weight[4])
    );

    etb_lane #(
        .ELEV_FRAC_BITS(ELEV_FRAC_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
        .P_SHAPE(SH_RISE), .P_A(LVL_1000), .P_B(LVL_5000)
    ) u_lane_stone_b (
        .i_clk(i_clk), .i_elevation(i_elevation), .o_weight(weight[5])
    );

    // hold texels alongside the lanes
    always_ff @(posedge i_clk) begin
        r_tex[0] <= tex_in;
        for (int s = 1; s < LANE_LAT; s++) begin
            r_tex[s] <= r_tex[s-1];
        end
    end

    etb_merge #(
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_weight (weight),
        .i_texel  (r_tex[LANE_LAT-1]),
        .o_chan   (chan)
    );

    assign n_vld = {r_vld[TOTAL_LAT-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid     = r_vld[TOTAL_LAT-1];
    assign o_out_red   = chan[0];
    assign o_out_green = chan[1];
    assign o_out_blue  = chan[2];

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##7 o_valid)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 7))
        else $error("result without matching word");

    a_low_water_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (i_elevation < ELEV_ONE_M)) |->
            ##7 (o_out_red == $past(i_texel_water[23:16], 7)))
        else $error("low elevation red differs from water texel");

    a_low_water_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (i_elevation < ELEV_ONE_M)) |->
            ##7 (o_out_blue == $past(i_texel_water[7:0], 7)))
        else $error("low elevation blue differs from water texel");

endmodule

>>> rtl/etb_lane.sv
module etb_lane import etb_pkg::*; #(
    parameter int     ELEV_FRAC_BITS   = DEF_ELEV_FRAC_BITS,
    parameter int     WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS,
    parameter t_shape P_SHAPE          = SH_FALL,
    parameter int     P_A              = 0,
    parameter int     P_B              = 1,
    parameter int     P_C              = 2,
    parameter int     P_D              = 3
) (
    input  logic                          i_clk,
    input  logic signed [ELEV_W-1:0]      i_elevation,
    output logic [WEIGHT_FRAC_BITS:0]     o_weight
);

    localparam int WF  = WEIGHT_FRAC_BITS;
    localparam int CW  = ((ELEV_W > 14 + ELEV_FRAC_BITS) ? ELEV_W : 14 + ELEV_FRAC_BITS) + 1;

    localparam longint A_U = longint'(P_A) << ELEV_FRAC_BITS;
    localparam longint B_U = longint'(P_B) << ELEV_FRAC_BITS;
    localparam longint C_U = longint'(P_C) << ELEV_FRAC_BITS;
    localparam longint D_U = longint'(P_D) << ELEV_FRAC_BITS;

    localparam longint SPAN0 = B_U - A_U;
    localparam longint SPAN1 = (P_SHAPE == SH_TRI)  ? C_U - B_U :
                               (P_SHAPE == SH_TRAP) ? D_U - C_U : SPAN0;

    localparam int L0 = $clog2(SPAN0);
    localparam int L1 = $clog2(SPAN1);
    localparam int NW = (L0 > L1) ? L0 : L1;

    localparam longint M0 = (longint'(1) << (WF + L0)) / SPAN0;
    localparam longint M1 = (longint'(1) << (WF + L1)) / SPAN1;

    localparam int MW = WF + 1;
    localparam int PW = NW + MW;
    localparam int QW = WF + NW;

    localparam logic signed [CW-1:0] BA  = CW'(A_U);
    localparam logic signed [CW-1:0] BB  = CW'(B_U);
    localparam logic signed [CW-1:0] BC  = CW'(C_U);
    localparam logic signed [CW-1:0] BD  = CW'(D_U);
    localparam logic signed [CW-1:0] SP0 = CW'(SPAN0);
    localparam logic signed [CW-1:0] SP1 = CW'(SPAN1);

    localparam logic [MW-1:0] REC0 = MW'(M0);
    localparam logic [MW-1:0] REC1 = MW'(M1);
    localparam logic [NW-1:0] SPN0 = NW'(SPAN0);
    localparam logic [NW-1:0] SPN1 = NW'(SPAN1);
    localparam logic [WF:0]   W_FULL = (WF + 1)'(1) << WF;

    logic signed [CW-1:0] e_x;
    logic signed [CW-1:0] diff;
    logic signed [CW-1:0] span;
    t_wcls                cls;
    logic                 sel;

    t_wcls          r_cls1, r_cls2, r_cls3;
    logic           r_sel1, r_sel2, r_sel3;
    logic [NW-1:0]  r_num1, r_num2, r_num3;
    logic [PW-1:0]  r_prod2;
    logic [WF-1:0]  r_q3;
    logic [QW-1:0]  r_qs3;

    logic [WF-1:0]  n_q3;
    logic [QW-1:0]  rem;
    logic           rem_ge;
    logic [WF:0]    n_weight;

    assign e_x = CW'(i_elevation);

    always_comb begin
        cls  = W_ZERO;
        diff = '0;
        sel  = 1'b0;
        case (P_SHAPE)
            SH_FALL: begin
                if (e_x < BA) begin
                    cls = W_ONE;
                end else if (e_x <= BB) begin
                    cls  = W_RAMP;
                    diff = BB - e_x;
                end
            end
            SH_TRI: begin
                if (e_x >= BA && e_x <= BC) begin
                    cls = W_RAMP;
                    if (e_x < BB) begin
                        diff = e_x - BA;
                    end else begin
                        diff = BC - e_x;
                        sel  = 1'b1;
                    end
                end
            end
            SH_TRAP: begin
                if (e_x >= BA && e_x <= BD) begin
                    if (e_x > BB && e_x < BC) begin
                        cls = W_ONE;
                    end else if (e_x <= BB) begin
                        cls  = W_RAMP;
                        diff = e_x - BA;
                    end else begin
                        cls  = W_RAMP;
                        diff = BD - e_x;
                        sel  = 1'b1;
                    end
                end
            end
            default: begin
                if (e_x > BB) begin
                    cls = W_ONE;
                end else if (e_x >= BA) begin
                    cls  = W_RAMP;
                    diff = e_x - BA;
                end
            end
        endcase
        span = sel ? SP1 : SP0;
        if (cls == W_RAMP) begin
            if (diff <= 0) begin
                cls = W_ZERO;
            end else if (diff >= span) begin
                cls = W_ONE;
            end
        end
    end

    always_comb begin
        n_q3 = r_sel2 ? WF'(r_prod2 >> L1) : WF'(r_prod2 >> L0);
    end

    always_comb begin
        rem    = {r_num3, {WF{1'b0}}} - r_qs3;
        rem_ge = rem >= QW'(r_sel3 ? SPN1 : SPN0);
        case (r_cls3)
            W_ONE:   n_weight = W_FULL;
            W_RAMP:  n_weight = {1'b0, r_q3} + (WF + 1)'(rem_ge);
            default: n_weight = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cls1   <= cls;
        r_sel1   <= sel;
        r_num1   <= NW'(diff);

        r_cls2   <= r_cls1;
        r_sel2   <= r_sel1;
        r_num2   <= r_num1;
        r_prod2  <= PW'(r_num1) * PW'(r_sel1 ? REC1 : REC0);

        r_cls3   <= r_cls2;
        r_sel3   <= r_sel2;
        r_num3   <= r_num2;
        r_q3     <= n_q3;
        r_qs3    <= QW'(n_q3) * QW'(r_sel2 ? SPN1 : SPN0);

        o_weight <= n_weight;
    end

endmodule

>>> rtl/etb_merge.sv
module etb_merge import etb_pkg::*; #(
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic [WEIGHT_FRAC_BITS:0] i_weight [N_TEX],
    input  logic [TEXEL_W-1:0]        i_texel  [N_TEX],
    output logic [CH_W-1:0]           o_chan   [N_CH]
);

    localparam int WF = WEIGHT_FRAC_BITS;
    localparam int PW = WF + 1 + CH_W;
    localparam int HW = PW + 2;
    localparam int SW = HW + 1;
    localparam int RW = SW - WF;
    localparam logic [RW-1:0] SAT = RW'((1 << CH_W) - 1);

    logic [PW-1:0]   r_prod [N_CH][N_TEX];
    logic [HW-1:0]   r_half [N_CH][2];
    logic [SW-1:0]   total  [N_CH];
    logic [RW-1:0]   shifted[N_CH];
    logic [CH_W-1:0] n_chan [N_CH];

    always_comb begin
        for (int ch = 0; ch < N_CH; ch++) begin
            total[ch]   = SW'(r_half[ch][0]) + SW'(r_half[ch][1]);
            shifted[ch] = RW'(total[ch] >> WF);
            n_chan[ch]  = (shifted[ch] > SAT) ? CH_W'(SAT) : CH_W'(shifted[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < N_CH; ch++) begin
            for (int t = 0; t < N_TEX; t++) begin
                r_prod[ch][t] <= PW'(i_weight[t]) *
                                 PW'(i_texel[t][(N_CH - 1 - ch) * CH_W +: CH_W]);
            end
            r_half[ch][0] <= HW'(r_prod[ch][0]) + HW'(r_prod[ch][1]) + HW'(r_prod[ch][2]);
            r_half[ch][1] <= HW'(r_prod[ch][3]) + HW'(r_prod[ch][4]) + HW'(r_prod[ch][5]);
            o_chan[ch]    <= n_chan[ch];
        end
    end

endmodule

>>> test/tb_elevation_texture_blend.sv
`timescale 1ns / 1ps

module tb_elevation_texture_blend;
    import etb_pkg::*;

    localparam int EFB         = DEF_ELEV_FRAC_BITS;
    localparam int WFB         = DEF_WEIGHT_FRAC_BITS;
    localparam int STALL_LIMIT = 2000;
    localparam int N_LEVELS    = 12;
    localparam int IDLE_PCT    = 29;

    typedef logic [N_TEX-1:0][TEXEL_W-1:0] t_texels;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [ELEV_W-1:0] drv_elev;
    t_texels                  drv_texels;
    logic                     o_valid;
    logic [CH_W-1:0]          o_out_red;
    logic [CH_W-1:0]          o_out_green;
    logic [CH_W-1:0]          o_out_blue;

    t_rgb rgb_expected_q[$];
    bit   gaps_on;
    int   mism_count;
    int   pixels_taken;
    int   saturated_ch;
    int   stall_cycles;

    elevation_texture_blend dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_elevation    (drv_elev),
        .i_texel_water  (drv_texels[0]),
        .i_texel_mud    (drv_texels[1]),
        .i_texel_grass_a(drv_texels[2]),
        .i_texel_grass_b(drv_texels[3]),
        .i_texel_stone_a(drv_texels[4]),
        .i_texel_stone_b(drv_texels[5]),
        .o_valid        (o_valid),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint meters(int lvl);
        return longint'(lvl) <<< EFB;
    endfunction

    function automatic int level_at(int idx);
        case (idx)
            0:       return LVL_1;
            1:       return LVL_5;
            2:       return LVL_10;
            3:       return LVL_20;
            4:       return LVL_25;
            5:       return LVL_100;
            6:       return LVL_500;
            7:       return LVL_600;
            8:       return LVL_800;
            9:       return LVL_1000;
            10:      return LVL_1500;
            default: return LVL_5000;
        endcase
    endfunction

    function automatic longint ramp_frac(longint num, longint span);
        if (span <= 0 || num <= 0) return 0;
        if (num >= span) return longint'(1) <<< WFB;
        return (num <<< WFB) / span;
    endfunction

    function automatic longint lane_weight(t_shape shape, longint e, int a, int b, int c, int d);
        longint pa;
        longint pb;
        longint pc;
        longint pd;
        longint one;
        pa  = meters(a);
        pb  = meters(b);
        pc  = meters(c);
        pd  = meters(d);
        one = longint'(1) <<< WFB;
        case (shape)
            SH_FALL: begin
                if (e < pa) return one;
                if (e > pb) return 0;
                return ramp_frac(pb - e, pb - pa);
            end
            SH_TRI: begin
                if (e < pa || e > pc) return 0;
                if (e < pb) return ramp_frac(e - pa, pb - pa);
                return ramp_frac(pc - e, pc - pb);
            end
            SH_TRAP: begin
                if (e < pa || e > pd) return 0;
                if (e > pb && e < pc) return one;
                if (e <= pb) return ramp_frac(e - pa, pb - pa);
                return ramp_frac(pd - e, pd - pc);
            end
            SH_RISE: begin
                if (e < pa) return 0;
                if (e > pb) return one;
                return ramp_frac(e - pa, pb - pa);
            end
            default: return 0;
        endcase
    endfunction

    function automatic t_rgb blend_pixel(logic signed [ELEV_W-1:0] elev, t_texels tex);
        longint          e;
        longint          w[N_TEX];
        longint          acc;
        logic [CH_W-1:0] chan[N_CH];
        t_rgb            rgb;
        e    = elev;
        w[0] = lane_weight(SH_FALL, e, LVL_1, LVL_10, 0, 0);
        w[1] = lane_weight(SH_TRI, e, LVL_1, LVL_5, LVL_20, 0);
        w[2] = lane_weight(SH_TRAP, e, LVL_5, LVL_25, LVL_500, LVL_600);
        w[3] = lane_weight(SH_TRAP, e, LVL_10, LVL_100, LVL_800, LVL_1000);
        w[4] = lane_weight(SH_RISE, e, LVL_500, LVL_1500, 0, 0);
        w[5] = lane_weight(SH_RISE, e, LVL_1000, LVL_5000, 0, 0);
        for (int ch = 0; ch < N_CH; ch++) begin
            acc = 0;
            for (int t = 0; t < N_TEX; t++) begin
                acc += w[t] * longint'(tex[t][(16 - 8 * ch) +: 8]);
            end
            acc = acc >>> WFB;
            chan[ch] = (acc > 255) ? 8'hFF : acc[CH_W-1:0];
        end
        rgb.red   = chan[0];
        rgb.green = chan[1];
        rgb.blue  = chan[2];
        return rgb;
    endfunction

    function automatic t_texels random_texels();
        t_texels tex;
        int      pick;
        pick = $urandom_range(99);
        for (int t = 0; t < N_TEX; t++) begin
            if (pick < 10) tex[t] = {TEXEL_W{1'b1}};
            else if (pick < 15) tex[t] = '0;
            else tex[t] = TEXEL_W'($urandom_range(0, (1 << TEXEL_W) - 1));
        end
        return tex;
    endfunction

    function automatic logic signed [ELEV_W-1:0] random_elevation();
        int pick;
        int e;
        pick = $urandom_range(99);
        if (pick < 55) e = $urandom_range(0, int'(meters(5200)));
        else if (pick < 75) e = int'(meters(level_at($urandom_range(0, N_LEVELS - 1))))
                                + $urandom_range(0, 80) - 40;
        else if (pick < 90) e = $urandom_range(0, (1 << ELEV_W) - 1);
        else e = -$urandom_range(1, 2000);
        return e[ELEV_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        mism_count++;
        if (mism_count <= 100) $display("mismatch: %s", msg);
    endtask

    // hold the word until start meets a low busy
    task automatic send_pixel(logic signed [ELEV_W-1:0] elev, t_texels tex);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        drv_elev   <= elev;
        drv_texels <= tex;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_rgb want;
        if (o_valid === 1'b1) begin
            if (rgb_expected_q.size() == 0) begin
                report_mismatch($sformatf("result %h%h%h with nothing pending",
                                          o_out_red, o_out_green, o_out_blue));
            end else begin
                want = rgb_expected_q.pop_front();
                if (o_out_red !== want.red)
                    report_mismatch($sformatf("red got %0d want %0d", o_out_red, want.red));
                if (o_out_green !== want.green)
                    report_mismatch($sformatf("green got %0d want %0d",
                                              o_out_green, want.green));
                if (o_out_blue !== want.blue)
                    report_mismatch($sformatf("blue got %0d want %0d", o_out_blue, want.blue));
            end
        end
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            want = blend_pixel(drv_elev, drv_texels);
            rgb_expected_q.push_back(want);
            pixels_taken++;
            saturated_ch += (want.red == 8'hFF) + (want.green == 8'hFF) + (want.blue == 8'hFF);
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic test_breakpoints();
        t_texels tex;
        for (int i = 0; i < N_LEVELS; i++) begin
            tex = (i % 2 == 0) ? {N_TEX{{TEXEL_W{1'b1}}}} : random_texels();
            send_pixel(ELEV_W'(meters(level_at(i))), tex);
        end
        send_pixel(ELEV_W'(meters(LVL_1) - 1), random_texels());
        send_pixel(ELEV_W'(meters(LVL_25) + 1), {N_TEX{{TEXEL_W{1'b1}}}});
        send_pixel(ELEV_W'(meters(LVL_500) - 1), random_texels());
        send_pixel(ELEV_W'(meters(LVL_5000) + 1), {N_TEX{{TEXEL_W{1'b1}}}});
    endtask

    task automatic test_extremes();
        send_pixel({1'b1, {(ELEV_W - 1){1'b0}}}, {N_TEX{{TEXEL_W{1'b1}}}});
        send_pixel({1'b0, {(ELEV_W - 1){1'b1}}}, {N_TEX{{TEXEL_W{1'b1}}}});
        send_pixel('0, '0);
        send_pixel({ELEV_W{1'b1}}, random_texels());
        send_pixel({1'b0, {(ELEV_W - 1){1'b1}}}, '0);
    endtask

    // weights overlapping above one drive every channel into the clamp; the 1000 m pixel stays below it
    task automatic test_saturation();
        send_pixel(ELEV_W'(meters(300)), {N_TEX{{TEXEL_W{1'b1}}}});
        send_pixel(ELEV_W'(meters(LVL_5) + 8), {N_TEX{{TEXEL_W{1'b1}}}});
        send_pixel(ELEV_W'(meters(LVL_1000)), {N_TEX{{TEXEL_W{1'b1}}}});
    endtask

    task automatic test_random_terrain(int count);
        for (int i = 0; i < count; i++) send_pixel(random_elevation(), random_texels());
    endtask

    task automatic test_back_to_back(int count);
        gaps_on = 1'b0;
        for (int i = 0; i < count; i++) send_pixel(random_elevation(), random_texels());
        gaps_on = 1'b1;
    endtask

    task automatic test_full_range(int count);
        logic signed [ELEV_W-1:0] e;
        for (int i = 0; i < count; i++) begin
            e = ELEV_W'($urandom_range(0, (1 << ELEV_W) - 1));
            send_pixel(e, random_texels());
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        drv_elev   <= '0;
        drv_texels <= '0;
        gaps_on     = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_breakpoints();
        test_extremes();
        test_saturation();
        test_random_terrain(1100);
        test_back_to_back(300);
        test_random_terrain(300);
        test_full_range(300);

        start <= 1'b0;
        while (rgb_expected_q.size() != 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 4) @(posedge i_clk);

        $display("blended %0d terrain pixels across all elevation bands and breakpoints,",
                 pixels_taken);
        $display("%0d channels clamped, %0d mismatches", saturated_ch, mism_count);
        if (mism_count == 0 && rgb_expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
